### hdl/wsfs_pkg.sv
// Shared types and constants for the weighted share feed scheduler.
// No dependencies.
package wsfs_pkg;

   // Command codes of an input item
   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_UPDATE  = 1'b1;

   // Register select bit of the CSR byte address (registers at 0 and 8)
   localparam int unsigned CSR_SEL_BIT = 3;
   localparam logic REG_ACTIVE_SOURCES = 1'b0;
   localparam logic REG_SOURCE_WEIGHTS = 1'b1;

   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned WEIGHT_W    = 8;
   localparam int unsigned NUM_WEIGHTS = 8;

   typedef struct packed {
      logic       command;
      logic [2:0] source_select;
      logic [7:0] stored_length;
   } req_type;

   typedef struct packed {
      logic       granted;
      logic [2:0] chosen_source;
      logic [7:0] item_position;
   } rsp_type;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_READ  = 9'b000000100,
      ST_SUM   = 9'b000001000,
      ST_WRAP  = 9'b000010000,
      ST_MULT  = 9'b000100000,
      ST_DEF   = 9'b001000000,
      ST_HALVE = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

endpackage

### hdl/wsfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wsfs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/weighted_share_feed_scheduler.sv
// Top level of the weighted share feed scheduler.
// Depends on wsfs_pkg and wsfs_ram.
//
// Usage:
//  - req channel (valid/ready, payload wsfs_pkg::req_type): a request item
//    (command 0) asks for the next source to read and its item position; an
//    update item (command 1) sets the stored length of source_select.
//  - rsp channel (valid/ready, payload wsfs_pkg::rsp_type): one item per
//    request item. Updates and requests with no active source return zeros.
//  - csr port (APB style, 64-bit data): active_sources at 0x0, eight packed
//    8-bit source weights at 0x8. Write only while the block is idle.
//  - Flow: an update or an empty request passes through ST_OUT to the rsp
//    register. A grant runs ST_READ, ST_SUM and ST_WRAP (next-index wrap),
//    then ST_MULT and ST_DEF for a deficit pick, and ST_HALVE when counts
//    are halved. The count RAM carries this: one entry per cycle is swept
//    for the weight/count sums, then again through the two-stage deficit
//    multiply/compare, then again for halving.
//  - One item is in flight at a time; a new item is taken while the last
//    result still sits in the rsp register.
//  - Reset: a clearing pass writes zero to every RAM entry, one entry per
//    cycle; req_ready stays low meanwhile.
//  - Output stall: a finished result waits in ST_OUT until the rsp register
//    frees up; nothing is lost.
module weighted_share_feed_scheduler #(
   parameter int unsigned MAX_SOURCES = 8,
   parameter int unsigned HALVE_LIMIT = 1000
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  wsfs_pkg::req_type                    req_data,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output wsfs_pkg::rsp_type                    rsp_data,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [wsfs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [wsfs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [wsfs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   // Index width, and count width able to hold MAX_SOURCES itself
   localparam int unsigned IW    = $clog2(MAX_SOURCES);
   localparam int unsigned CNT_W = IW + 1;
   localparam int unsigned CW    = wsfs_pkg::COUNT_W;
   localparam int unsigned WW    = wsfs_pkg::WEIGHT_W;
   // Sum of weights, sum of counts, products, deficit
   localparam int unsigned W_W   = WW + CNT_W;
   localparam int unsigned T_W   = CW + CNT_W;
   localparam int unsigned P_W   = WW + T_W;
   localparam int unsigned WT_W  = W_W + T_W;
   localparam int unsigned D_W   = WT_W + 1;

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   wsfs_pkg::state_type   state_ff, state_in;
   logic [IW-1:0]         clr_ff, clr_in;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;       // sweep issue index
   logic                  dv_ff, dv_in;         // RAM read data valid
   logic [IW-1:0]         didx_ff, didx_in;     // index of RAM read data
   logic                  pv_ff, pv_in;         // products valid
   logic [IW-1:0]         pidx_ff, pidx_in;
   logic [P_W-1:0]        pa_ff, pa_in;         // w_i * T
   logic [P_W-1:0]        pb_ff, pb_in;         // c_i * W
   logic [W_W-1:0]        w_sum_ff, w_sum_in;
   logic [T_W-1:0]        t_sum_ff, t_sum_in;
   logic [CW-1:0]         cnt0_ff, cnt0_in;
   logic [CNT_W-1:0]      nxt_ff, nxt_in;
   logic signed [D_W-1:0] best_ff, best_in;
   wsfs_pkg::rsp_type     res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   wsfs_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   logic [3:0]            active_ff, active_in;
   logic [63:0]           weights_ff, weights_in;

   // ---------------------------------------------------------------
   // RAMs: item positions, stored lengths, read counts
   // ---------------------------------------------------------------
   logic          pos_we, len_we, cnt_we;
   logic [IW-1:0] pos_waddr, len_waddr, cnt_waddr, cnt_raddr;
   logic [7:0]    pos_wdata, len_wdata, pos_rd, len_rd;
   logic [CW-1:0] cnt_wdata, cnt_rd;

   wsfs_ram #(.WIDTH(8), .DEPTH(MAX_SOURCES)) u_pos_ram (
      .clock  (clock),
      .wr_en  (pos_we),
      .wr_addr(pos_waddr),
      .wr_data(pos_wdata),
      .rd_addr(cur_ff),
      .rd_data(pos_rd)
   );

   wsfs_ram #(.WIDTH(8), .DEPTH(MAX_SOURCES)) u_len_ram (
      .clock  (clock),
      .wr_en  (len_we),
      .wr_addr(len_waddr),
      .wr_data(len_wdata),
      .rd_addr(cur_ff),
      .rd_data(len_rd)
   );

   wsfs_ram #(.WIDTH(CW), .DEPTH(MAX_SOURCES)) u_cnt_ram (
      .clock  (clock),
      .wr_en  (cnt_we),
      .wr_addr(cnt_waddr),
      .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr),
      .rd_data(cnt_rd)
   );

   // ---------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------
   logic [4:0]            act_ext;
   logic [CNT_W-1:0]      n_act;        // active count, clamped
   logic                  iss;          // sweep still issuing reads
   logic [IW+3:0]         didx_ext;
   logic [WW-1:0]         w_sel;        // weight of didx_ff
   logic [4:0]            sel_ext;
   logic                  sel_ok;
   logic [8:0]            pos_inc;
   logic [WT_W-1:0]       wt_prod;
   logic signed [D_W-1:0] d_val;
   logic                  req_fire, csr_wr, halve;
   logic [IW+2:0]         cur_ext;

   assign act_ext = {1'b0, active_ff};
   assign n_act   = (act_ext > 5'(MAX_SOURCES)) ? CNT_W'(MAX_SOURCES)
                                                : act_ext[CNT_W-1:0];
   assign iss     = (idx_ff < n_act);

   // Sources at index 8 and above carry no weight
   assign didx_ext = {4'b0000, didx_ff};
   always_comb begin
      w_sel = '0;
      for (int k = 0; k < wsfs_pkg::NUM_WEIGHTS; k++) begin
         if (didx_ext == (IW+4)'(k)) begin
            w_sel = weights_ff[WW*k +: WW];
         end
      end
   end

   assign sel_ext = {2'b00, req_data.source_select};
   assign sel_ok  = (sel_ext < 5'(MAX_SOURCES));
   assign pos_inc = {1'b0, pos_rd} + 9'd1;
   assign wt_prod = WT_W'(w_sum_ff) * WT_W'(t_sum_ff);
   assign d_val   = $signed({{(D_W-P_W){1'b0}}, pa_ff})
                  - $signed({{(D_W-P_W){1'b0}}, pb_ff});
   assign halve   = (cnt0_ff > CW'(HALVE_LIMIT));
   assign cur_ext = {3'b000, cur_ff};

   assign req_ready = (state_ff == wsfs_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // ---------------------------------------------------------------
   // RAM port control
   // ---------------------------------------------------------------
   always_comb begin
      pos_we    = 1'b0;
      pos_waddr = cur_ff;
      pos_wdata = (pos_inc >= {1'b0, len_rd}) ? 8'd0 : pos_inc[7:0];
      len_we    = 1'b0;
      len_waddr = sel_ext[IW-1:0];
      len_wdata = req_data.stored_length;
      cnt_we    = 1'b0;
      cnt_waddr = cur_ff;
      cnt_wdata = (cnt_rd == '1) ? cnt_rd : cnt_rd + CW'(1);
      cnt_raddr = (state_ff == wsfs_pkg::ST_IDLE) ? cur_ff : idx_ff[IW-1:0];
      unique case (state_ff)
         wsfs_pkg::ST_CLEAR: begin
            pos_we    = 1'b1;
            pos_waddr = clr_ff;
            pos_wdata = '0;
            len_we    = 1'b1;
            len_waddr = clr_ff;
            len_wdata = '0;
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
         end
         wsfs_pkg::ST_IDLE: begin
            len_we = req_fire && (req_data.command == wsfs_pkg::CMD_UPDATE) && sel_ok;
         end
         wsfs_pkg::ST_READ: begin
            // advance position, bump count (saturating)
            pos_we = 1'b1;
            cnt_we = 1'b1;
         end
         wsfs_pkg::ST_HALVE: begin
            cnt_we    = dv_ff;
            cnt_waddr = didx_ff;
            cnt_wdata = cnt_rd >> 1;
         end
         wsfs_pkg::ST_SUM, wsfs_pkg::ST_WRAP, wsfs_pkg::ST_MULT,
         wsfs_pkg::ST_DEF, wsfs_pkg::ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      dv_in        = 1'b0;
      didx_in      = idx_ff[IW-1:0];
      pv_in        = 1'b0;
      pidx_in      = didx_ff;
      pa_in        = P_W'(w_sel) * P_W'(t_sum_ff);
      pb_in        = P_W'(cnt_rd) * P_W'(w_sum_ff);
      w_sum_in     = w_sum_ff;
      t_sum_in     = t_sum_ff;
      cnt0_in      = cnt0_ff;
      nxt_in       = nxt_ff;
      best_in      = best_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      active_in    = active_ff;
      weights_in   = weights_ff;

      if (csr_wr) begin
         unique case (csr_paddr[wsfs_pkg::CSR_SEL_BIT])
            wsfs_pkg::REG_ACTIVE_SOURCES: active_in  = csr_pwdata[3:0];
            wsfs_pkg::REG_SOURCE_WEIGHTS: weights_in = csr_pwdata;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         wsfs_pkg::ST_CLEAR: begin
            clr_in = clr_ff + IW'(1);
            if (clr_ff == IW'(MAX_SOURCES - 1)) begin
               state_in = wsfs_pkg::ST_IDLE;
            end
         end

         wsfs_pkg::ST_IDLE: begin
            if (req_fire) begin
               res_in = '0;
               if (req_data.command == wsfs_pkg::CMD_UPDATE || n_act == '0) begin
                  state_in = wsfs_pkg::ST_OUT;
               end else begin
                  state_in = wsfs_pkg::ST_READ;
               end
            end
         end

         wsfs_pkg::ST_READ: begin
            res_in.granted       = 1'b1;
            res_in.chosen_source = cur_ext[2:0];
            res_in.item_position = pos_rd;
            nxt_in   = {1'b0, cur_ff} + CNT_W'(1);
            idx_in   = '0;
            w_sum_in = '0;
            t_sum_in = '0;
            state_in = wsfs_pkg::ST_SUM;
         end

         // Sweep counts after the increment: W, T and count 0
         wsfs_pkg::ST_SUM: begin
            if (iss) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            dv_in = iss;
            if (dv_ff) begin
               w_sum_in = w_sum_ff + W_W'(w_sel);
               t_sum_in = t_sum_ff + T_W'(cnt_rd);
               if (didx_ff == '0) begin
                  cnt0_in = cnt_rd;
               end
            end
            if (!iss && !dv_ff) begin
               state_in = wsfs_pkg::ST_WRAP;
            end
         end

         // Default next index: (cur + 1) mod n by repeated subtraction
         wsfs_pkg::ST_WRAP: begin
            if (n_act > CNT_W'(1) && nxt_ff >= n_act) begin
               nxt_in = nxt_ff - n_act;
            end else if (n_act > CNT_W'(1) && t_sum_ff != '0) begin
               state_in = wsfs_pkg::ST_MULT;
            end else begin
               cur_in   = (n_act > CNT_W'(1)) ? nxt_ff[IW-1:0] : '0;
               idx_in   = '0;
               state_in = halve ? wsfs_pkg::ST_HALVE : wsfs_pkg::ST_OUT;
            end
         end

         wsfs_pkg::ST_MULT: begin
            best_in  = -$signed({1'b0, wt_prod});
            idx_in   = '0;
            state_in = wsfs_pkg::ST_DEF;
         end

         // Deficit argmax: read, multiply, compare (first max wins)
         wsfs_pkg::ST_DEF: begin
            if (iss) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            dv_in = iss;
            pv_in = dv_ff;
            if (pv_ff && d_val > best_ff) begin
               best_in = d_val;
               nxt_in  = {1'b0, pidx_ff};
            end
            if (!iss && !dv_ff && !pv_ff) begin
               cur_in   = nxt_ff[IW-1:0];
               idx_in   = '0;
               state_in = halve ? wsfs_pkg::ST_HALVE : wsfs_pkg::ST_OUT;
            end
         end

         wsfs_pkg::ST_HALVE: begin
            if (iss) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            dv_in = iss;
            if (!iss && !dv_ff) begin
               state_in = wsfs_pkg::ST_OUT;
            end
         end

         wsfs_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = wsfs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = wsfs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsfs_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cur_ff       <= '0;
         idx_ff       <= '0;
         dv_ff        <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
         weights_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_ff       <= cur_in;
         idx_ff       <= idx_in;
         dv_ff        <= dv_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         weights_ff   <= weights_in;
      end
      didx_ff     <= didx_in;
      pidx_ff     <= pidx_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      w_sum_ff    <= w_sum_in;
      t_sum_ff    <= t_sum_in;
      cnt0_ff     <= cnt0_in;
      nxt_ff      <= nxt_in;
      best_ff     <= best_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[wsfs_pkg::CSR_SEL_BIT] == wsfs_pkg::REG_SOURCE_WEIGHTS)
                       ? weights_ff
                       : {{(wsfs_pkg::CSR_DATA_W-4){1'b0}}, active_ff};

endmodule

### tb/wsfs_checker.sv
`timescale 1ns / 1ps
// Checker for the weighted share feed scheduler: follows CSR traffic, predicts
// every rsp item from the accepted req items and compares. Depends on wsfs_pkg.
module wsfs_checker #(
   parameter int unsigned MAX_SOURCES = 8,
   parameter int unsigned HALVE_LIMIT = 1000
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  wsfs_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  wsfs_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [wsfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wsfs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [wsfs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output int                              fault_count,
   output int                              grants_owed
);

   logic [3:0]                      active_cfg;
   logic [wsfs_pkg::CSR_DATA_W-1:0] weight_cfg;
   int unsigned                     serve_src;
   logic [7:0]                      position_tab [MAX_SOURCES];
   logic [wsfs_pkg::COUNT_W-1:0]    count_tab    [MAX_SOURCES];
   logic [7:0]                      length_tab   [MAX_SOURCES];
   wsfs_pkg::rsp_type               pending_grants [$];

   function automatic longint weight_of(int unsigned i);
      if (i >= wsfs_pkg::NUM_WEIGHTS)
         return 0;
      return longint'(weight_cfg[wsfs_pkg::WEIGHT_W*i +: wsfs_pkg::WEIGHT_W]);
   endfunction

   // Update: store length. Request: serve, then pick next by largest deficit.
   function automatic wsfs_pkg::rsp_type schedule_pick(wsfs_pkg::req_type it);
      wsfs_pkg::rsp_type pick;
      int unsigned       n, nxt, cur, pos, i;
      longint            wsum, csum, best, gap;
      pick = '0;
      if (it.command == wsfs_pkg::CMD_UPDATE) begin
         if (it.source_select < MAX_SOURCES)
            length_tab[it.source_select] = it.stored_length;
         return pick;
      end
      n = (active_cfg > MAX_SOURCES) ? MAX_SOURCES : active_cfg;
      if (n == 0 || serve_src >= MAX_SOURCES)
         return pick;
      cur = serve_src;
      pick.granted       = 1'b1;
      pick.chosen_source = 3'(cur);
      pick.item_position = position_tab[cur];
      pos = position_tab[cur] + 1;
      if (pos >= length_tab[cur])
         pos = 0;
      position_tab[cur] = 8'(pos);
      if (count_tab[cur] != '1)
         count_tab[cur] = count_tab[cur] + 1'b1;
      if (n > 1) begin
         nxt  = (cur + 1) % n;
         wsum = 0;
         csum = 0;
         for (i = 0; i < n; i++) begin
            wsum += weight_of(i);
            csum += longint'(count_tab[i]);
         end
         if (csum > 0) begin
            best = -(wsum * csum);
            for (i = 0; i < n; i++) begin
               gap = weight_of(i) * csum - longint'(count_tab[i]) * wsum;
               if (gap > best) begin
                  best = gap;
                  nxt  = i;
               end
            end
         end
         serve_src = nxt;
      end else begin
         serve_src = 0;
      end
      if (count_tab[0] > HALVE_LIMIT)
         for (i = 0; i < n; i++)
            count_tab[i] = count_tab[i] >> 1;
      return pick;
   endfunction

   always @(posedge clock) begin : watch
      wsfs_pkg::rsp_type               want;
      logic [wsfs_pkg::CSR_DATA_W-1:0] reg_val;
      if (reset) begin
         active_cfg  = '0;
         weight_cfg  = '0;
         serve_src   = 0;
         fault_count = 0;
         for (int i = 0; i < MAX_SOURCES; i++) begin
            position_tab[i] = '0;
            count_tab[i]    = '0;
            length_tab[i]   = '0;
         end
         pending_grants.delete();
         grants_owed <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[wsfs_pkg::CSR_SEL_BIT])
                  wsfs_pkg::REG_ACTIVE_SOURCES: active_cfg = csr_pwdata[3:0];
                  wsfs_pkg::REG_SOURCE_WEIGHTS: weight_cfg = csr_pwdata;
               endcase
            end else begin
               reg_val = (csr_paddr[wsfs_pkg::CSR_SEL_BIT] == wsfs_pkg::REG_SOURCE_WEIGHTS)
                         ? weight_cfg : wsfs_pkg::CSR_DATA_W'(active_cfg);
               if (csr_prdata !== reg_val) begin
                  $error("csr_prdata: expected %h, got %h", reg_val, csr_prdata);
                  fault_count++;
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_grants.size() == 0) begin
               $error("rsp item %h with no request outstanding", rsp_data);
               fault_count++;
            end else begin
               want = pending_grants.pop_front();
               if (rsp_data.granted !== want.granted) begin
                  $error("granted: expected %0d, got %0d", want.granted, rsp_data.granted);
                  fault_count++;
               end
               if (rsp_data.chosen_source !== want.chosen_source) begin
                  $error("chosen_source: expected %0d, got %0d",
                         want.chosen_source, rsp_data.chosen_source);
                  fault_count++;
               end
               if (rsp_data.item_position !== want.item_position) begin
                  $error("item_position: expected %0d, got %0d",
                         want.item_position, rsp_data.item_position);
                  fault_count++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_grants.insert(pending_grants.size(), schedule_pick(req_data));
         grants_owed <= pending_grants.size();
      end
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the weighted share feed scheduler testbench: clock, reset, stimulus,
// flow control and verdict. Depends on wsfs_pkg, wsfs_checker and the RTL.
module testbench;

   localparam int unsigned SOURCES       = 8;
   localparam int unsigned HALVE_AT      = 1000;
   localparam int unsigned STALL_LIMIT   = 3000;  // cycles without any handshake
   localparam int unsigned HOLD_CYCLES   = 400;   // long rsp back-pressure stretch
   localparam int unsigned SOAK_REQUESTS = 100;   // single-source run
   localparam int unsigned RANDOM_ITEMS  = 728;
   localparam int unsigned PHASES        = 8;
   localparam int unsigned SETTLE_CYCLES = 60;    // > worst grant latency

   typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   wsfs_pkg::req_type               req_data    = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   wsfs_pkg::rsp_type               rsp_data;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [wsfs_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [wsfs_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [wsfs_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   int          faults;
   int          grants_owed;
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_req  = 0;   // bumped by stimulus to ask for a long hold
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   always #6 clock = ~clock;

   weighted_share_feed_scheduler #(
      .MAX_SOURCES(SOURCES),
      .HALVE_LIMIT(HALVE_AT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   wsfs_checker #(
      .MAX_SOURCES(SOURCES),
      .HALVE_LIMIT(HALVE_AT)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_pready (csr_pready),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .fault_count(faults),
      .grants_owed(grants_owed)
   );

   // Result side. A change of hold_req starts a long stretch with rsp_ready
   // low so the scheduler backs up into its input; otherwise ready drops at
   // the current stall rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Watchdog: any handshake on any port restarts the count. The clearing
   // pass after reset and the long hold both stay far below the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic wsfs_pkg::req_type make_item(logic cmd, logic [2:0] sel,
                                                   logic [7:0] len);
      wsfs_pkg::req_type it;
      it.command       = cmd;
      it.source_select = sel;
      it.stored_length = len;
      return it;
   endfunction

   // Mostly requests; updates favor short lengths so positions wrap often,
   // with zero and full-scale lengths mixed in.
   function automatic wsfs_pkg::req_type random_item();
      wsfs_pkg::req_type it;
      it.command       = ($urandom_range(0, 99) < 20) ? wsfs_pkg::CMD_UPDATE
                                                      : wsfs_pkg::CMD_REQUEST;
      it.source_select = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
         0:       it.stored_length = 8'd0;
         1:       it.stored_length = 8'd255;
         2:       it.stored_length = 8'($urandom);
         default: it.stored_length = 8'($urandom_range(1, 12));
      endcase
      return it;
   endfunction

   function automatic logic [wsfs_pkg::CSR_DATA_W-1:0] random_weights();
      logic [wsfs_pkg::CSR_DATA_W-1:0] w;
      int unsigned                     b;
      w = '0;
      if ($urandom_range(0, 9) == 0)
         return w;   // all-zero weights: plain round robin
      for (b = 0; b < wsfs_pkg::NUM_WEIGHTS; b++)
         case ($urandom_range(0, 7))
            0:       w[wsfs_pkg::WEIGHT_W*b +: wsfs_pkg::WEIGHT_W] = 8'h00;
            1:       w[wsfs_pkg::WEIGHT_W*b +: wsfs_pkg::WEIGHT_W] = 8'hFF;
            default: w[wsfs_pkg::WEIGHT_W*b +: wsfs_pkg::WEIGHT_W] =
                        8'($urandom_range(1, 255));
         endcase
      return w;
   endfunction

   // Source count: usually 2..8, sometimes none/one, sometimes over the max
   function automatic logic [3:0] random_active();
      case ($urandom_range(0, 9))
         0:       return 4'($urandom_range(0, 1));
         1:       return 4'($urandom_range(9, 15));
         default: return 4'($urandom_range(2, 8));
      endcase
   endfunction

   task automatic set_pace(pace_type p);
      sender_idle_pct    = (p == PACE_SENDER)   ? 65 : (p == PACE_BOTH) ? 17 : 0;
      receiver_stall_pct = (p == PACE_RECEIVER) ? 65 : (p == PACE_BOTH) ? 17 : 0;
   endtask

   // Offers one item and returns at the edge where it is taken. valid stays
   // high afterward so back-to-back items need no extra assignment.
   task automatic send_item(wsfs_pkg::req_type it);
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait until every predicted item has come back.
   // grants_owed is a registered copy of the queue size, hence the first wait.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (grants_owed != 0)
         @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access until pready
   task automatic csr_access(logic wr, logic idx, logic [wsfs_pkg::CSR_DATA_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= wsfs_pkg::CSR_ADDR_W'(idx) << wsfs_pkg::CSR_SEL_BIT;
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Registers change only with the block idle; read both back afterward.
   task automatic configure(logic [3:0] active, logic [wsfs_pkg::CSR_DATA_W-1:0] weights);
      drain();
      csr_access(1'b1, wsfs_pkg::REG_ACTIVE_SOURCES, wsfs_pkg::CSR_DATA_W'(active));
      csr_access(1'b1, wsfs_pkg::REG_SOURCE_WEIGHTS, weights);
      csr_access(1'b0, wsfs_pkg::REG_ACTIVE_SOURCES, '0);
      csr_access(1'b0, wsfs_pkg::REG_SOURCE_WEIGHTS, '0);
   endtask

   initial begin : stimulus
      int unsigned ph, k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_pace(PACE_FREE);

      // --- directed ---
      // nothing active yet: a request comes back empty
      send_item(make_item(wsfs_pkg::CMD_REQUEST, 3'd0, 8'd0));
      // length updates at the extremes; source 0 gets zero length (wraps each read)
      send_item(make_item(wsfs_pkg::CMD_UPDATE, 3'd7, 8'd255));
      send_item(make_item(wsfs_pkg::CMD_UPDATE, 3'd0, 8'd0));
      send_item(make_item(wsfs_pkg::CMD_UPDATE, 3'd1, 8'd2));
      send_item(make_item(wsfs_pkg::CMD_UPDATE, 3'd2, 8'd255));

      // zero weights -> round robin 0,1,2,0,1 leaves source 2 up next
      configure(4'd3, '0);
      repeat (5) send_item(make_item(wsfs_pkg::CMD_REQUEST, 3'd0, 8'd0));

      // shrink below the pending source: it is still served once
      configure(4'd2, '0);
      repeat (2) send_item(make_item(wsfs_pkg::CMD_REQUEST, 3'd0, 8'd0));

      // count over the max clamps to eight; full-scale weights
      configure(4'd15, '1);
      repeat (4) send_item(make_item(wsfs_pkg::CMD_REQUEST, 3'd0, 8'd0));

      // uneven weights; ignored request fields at their top values
      configure(4'd8, 64'h00FF_0180_7F01_FE02);
      repeat (4) send_item(make_item(wsfs_pkg::CMD_REQUEST, 3'd7, 8'd255));

      // single source: every grant leaves source 0 up next
      configure(4'd1, 64'h0000_0000_0000_0001);
      repeat (2) send_item(make_item(wsfs_pkg::CMD_REQUEST, 3'd0, 8'd0));

      // --- single-source run: source 0 count climbs steadily ---
      configure(4'd1, random_weights());
      for (k = 0; k < SOAK_REQUESTS; k++)
         send_item(make_item(wsfs_pkg::CMD_REQUEST, 3'($urandom_range(0, 7)),
                             8'($urandom)));

      // --- random phases, cycling through the pacing modes ---
      for (ph = 0; ph < PHASES; ph++) begin
         configure((ph == 0 || ph == PHASES - 1) ? 4'd8 : random_active(),
                   (ph == PHASES - 1) ? '1 : random_weights());
         set_pace(pace_type'(ph % 4));
         if (ph == 4)
            hold_req = hold_req + 1;   // long rsp hold while items keep coming
         for (k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
            if (ph == 1 && k == RANDOM_ITEMS / PHASES / 2)
               drain();                // sender pause until all results are back
            send_item(random_item());
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (faults == 0 && grants_owed == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
